@@ rtl/rrt_pkg.sv @@
// Shared types, codes and constants of the reception range tracker.
package rrt_pkg;

  // Offset space of the tracker; SPACE_END is built on it, the field widths below match it.
  localparam int unsigned OFFSET_WIDTH = 32;
  localparam int unsigned DEF_MAX_RANGES = 16;
  localparam logic [OFFSET_WIDTH:0] SPACE_END = {1'b1, {OFFSET_WIDTH{1'b0}}};

  // Request types.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_GAPS = 1'b1;

  // Result status codes.
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;
  localparam logic [1:0] STS_OVF   = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [31:0] range_offset;
    logic [31:0] range_length;
    logic [31:0] query_lower;
    logic [32:0] query_upper;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        gap_valid;
    logic [31:0] gap_start;
    logic [32:0] gap_length;
    logic        last;
    logic        complete;
    logic [32:0] received_bytes;
    logic [4:0]  stored_ranges;
  } out_item_t;

  // One stored range: begin and exclusive stop.
  typedef struct packed {
    logic [31:0] rbeg;
    logic [32:0] rstop;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ATAIL,
    ST_QTAIL,
    ST_FINAL
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic insert;
    logic atail;
    logic qtail;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early;
    logic is_query;
    logic add_end;
    logic q_end;
    logic insert_now;
    logic gap_found;
    logic tail_gap;
    logic pend_v;
    logic can_emit;
  } sts_t;

endpackage

@@ rtl/rrt_ctrl.sv @@
// Controller state machine of the reception range tracker.
module rrt_ctrl import rrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.early ? ST_FINAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.is_query && sts_i.q_end) begin
          state_d = ST_QTAIL;
        end else if (!sts_i.is_query && sts_i.add_end) begin
          state_d = ST_ATAIL;
        end
      end
      ST_ATAIL: state_d = ST_FINAL;
      ST_QTAIL: begin
        if (!(sts_i.tail_gap && sts_i.pend_v && !sts_i.can_emit)) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (sts_i.can_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_SCAN: begin
        if (sts_i.is_query) begin
          if (!sts_i.q_end && !(sts_i.gap_found && sts_i.pend_v && !sts_i.can_emit)) begin
            cmd_o.step = 1'b1;
          end
        end else if (!sts_i.add_end) begin
          cmd_o.insert = sts_i.insert_now;
          cmd_o.step   = !sts_i.insert_now;
        end
      end
      ST_ATAIL: cmd_o.atail = 1'b1;
      ST_QTAIL: cmd_o.qtail = !(sts_i.tail_gap && sts_i.pend_v && !sts_i.can_emit);
      ST_FINAL: cmd_o.fin = sts_i.can_emit;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/rrt_datapath.sv @@
// Datapath of the reception range tracker: range table, merge and gap scan, result register.
module rrt_datapath import rrt_pkg::*; #(
  parameter int unsigned MAX_RANGES = DEF_MAX_RANGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  in_item_t    in_item_i,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

  // Two banks: the current table is read while the updated one is written.
  entry_t mem [2**(AW+1)];
  entry_t rdata_q;

  logic [31:0]   blen_q;
  logic          sel_q;
  logic [CW-1:0] idx_q, idx_d, widx_q, widx_d, total_q;
  logic [32:0]   bytes_q, sum_q, sum_d;
  logic [31:0]   s_q, s_d;
  logic [32:0]   e_q, e_d;
  logic          ins_q, merged_q, isq_q;
  logic [32:0]   cur_q, hi_q;
  logic          pend_v_q;
  logic [31:0]   pend_s_q;
  logic [32:0]   pend_l_q;
  logic [1:0]    status_q;
  logic [31:0]   first_b_q, nf_b_q, nf_b_d;
  logic [32:0]   first_t_q, nf_t_q, nf_t_d;
  logic          out_v_q;
  out_item_t     out_q;

  logic          t_lt_s, b_le_e, can_emit, complete;
  logic          wr_want, wr_en, drop;
  logic [31:0]   wr_b;
  logic [32:0]   wr_t, gend, in_end, in_hi;

  // Entry compares against the range being added and the query window end.
  assign t_lt_s   = rdata_q.rstop < {1'b0, s_q};
  assign b_le_e   = {1'b0, rdata_q.rbeg} <= e_q;
  assign can_emit = !out_v_q || !out_stall_i;
  assign gend     = ({1'b0, rdata_q.rbeg} < hi_q) ? {1'b0, rdata_q.rbeg} : hi_q;
  assign in_end   = {1'b0, in_item_i.range_offset} + {1'b0, in_item_i.range_length};
  assign in_hi    = (in_item_i.query_upper > SPACE_END) ? SPACE_END : in_item_i.query_upper;
  assign complete = (blen_q == '0) ||
                    (total_q == CW'(1) && first_b_q == '0 && first_t_q >= {1'b0, blen_q});

  always_comb begin
    sts_o.early      = (in_item_i.req_type == REQ_ADD) &&
                       (in_item_i.range_length == '0 || in_end > SPACE_END);
    sts_o.is_query   = isq_q;
    sts_o.add_end    = (idx_q == total_q);
    sts_o.q_end      = (idx_q == total_q) || (cur_q >= hi_q);
    sts_o.insert_now = !ins_q && !t_lt_s && !b_le_e;
    sts_o.gap_found  = !sts_o.q_end && (rdata_q.rstop > cur_q) &&
                       ({1'b0, rdata_q.rbeg} > cur_q);
    sts_o.tail_gap   = cur_q < hi_q;
    sts_o.pend_v     = pend_v_q;
    sts_o.can_emit   = can_emit;
  end

  // Table write selection for the add merge.
  always_comb begin
    wr_want = 1'b0;
    wr_b    = rdata_q.rbeg;
    wr_t    = rdata_q.rstop;
    if (cmd_i.step && !isq_q && (ins_q || t_lt_s)) begin
      wr_want = 1'b1;
    end else if (cmd_i.insert || (cmd_i.atail && !ins_q)) begin
      wr_want = 1'b1;
      wr_b    = s_q;
      wr_t    = e_q;
    end
    wr_en  = wr_want && (widx_q < MAX_CNT);
    widx_d = widx_q + CW'(wr_en);
    sum_d  = wr_en ? sum_q + (wr_t - {1'b0, wr_b}) : sum_q;
    nf_b_d = (wr_en && widx_q == '0) ? wr_b : nf_b_q;
    nf_t_d = (wr_en && widx_q == '0) ? wr_t : nf_t_q;
    drop   = !merged_q && (total_q >= MAX_CNT);
  end

  // Read index follows the scan counter so read data matches idx_q.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + CW'(1);
    end
  end

  // Merged range bounds, starting from the new range when an item is taken.
  always_comb begin
    s_d = s_q;
    e_d = e_q;
    if (cmd_i.load) begin
      s_d = in_item_i.range_offset;
      e_d = in_end;
    end else if (cmd_i.step && !isq_q && !ins_q && !t_lt_s && b_le_e) begin
      s_d = (rdata_q.rbeg < s_q) ? rdata_q.rbeg : s_q;
      e_d = (rdata_q.rstop > e_q) ? rdata_q.rstop : e_q;
    end
  end

  // Range memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{~sel_q, widx_q[AW-1:0]}] <= '{rbeg: wr_b, rstop: wr_t};
    end
    rdata_q <= mem[{sel_q, idx_d[AW-1:0]}];
  end

  // Control and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q   <= '0;
      sel_q    <= 1'b0;
      total_q  <= '0;
      bytes_q  <= '0;
      idx_q    <= '0;
      widx_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      ins_q    <= 1'b0;
      merged_q <= 1'b0;
      isq_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        blen_q <= cfg_data_i;
      end
      idx_q  <= idx_d;
      widx_q <= cmd_i.load ? '0 : widx_d;
      if (cmd_i.load) begin
        isq_q    <= (in_item_i.req_type == REQ_GAPS);
        ins_q    <= 1'b0;
        merged_q <= 1'b0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.insert || (cmd_i.step && !isq_q && ins_q)) begin
        ins_q <= 1'b1;
      end
      if (cmd_i.step && !isq_q && !ins_q && !t_lt_s && b_le_e) begin
        merged_q <= 1'b1;
      end
      if ((cmd_i.step && isq_q && sts_o.gap_found) || (cmd_i.qtail && sts_o.tail_gap)) begin
        pend_v_q <= 1'b1;
      end
      if (cmd_i.atail && !drop) begin
        sel_q   <= ~sel_q;
        total_q <= widx_d;
        bytes_q <= sum_d;
      end
      if ((cmd_i.step && isq_q && sts_o.gap_found && pend_v_q) ||
          (cmd_i.qtail && sts_o.tail_gap && pend_v_q) || cmd_i.fin) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    e_q    <= e_d;
    sum_q  <= cmd_i.load ? '0 : sum_d;
    nf_b_q <= nf_b_d;
    nf_t_q <= nf_t_d;
    if (cmd_i.load) begin
      cur_q <= {1'b0, in_item_i.query_lower};
      hi_q  <= in_hi;
      if (in_item_i.req_type == REQ_GAPS) begin
        status_q <= STS_OK;
      end else if (in_item_i.range_length == '0) begin
        status_q <= STS_EMPTY;
      end else if (in_end > SPACE_END) begin
        status_q <= STS_OVF;
      end else begin
        status_q <= STS_OK;
      end
    end
    if (cmd_i.atail) begin
      status_q <= drop ? STS_FULL : STS_OK;
      if (!drop) begin
        first_b_q <= nf_b_d;
        first_t_q <= nf_t_d;
      end
    end
    // Query scan: move the cursor past each range, hold one gap back for the last mark.
    if (cmd_i.step && isq_q) begin
      if (rdata_q.rstop > cur_q) begin
        cur_q <= rdata_q.rstop;
      end
      if (sts_o.gap_found) begin
        pend_s_q <= cur_q[31:0];
        pend_l_q <= gend - cur_q;
      end
    end
    if (cmd_i.qtail && sts_o.tail_gap) begin
      pend_s_q <= cur_q[31:0];
      pend_l_q <= hi_q - cur_q;
    end
    // Result register.
    if ((cmd_i.step && isq_q && sts_o.gap_found && pend_v_q) ||
        (cmd_i.qtail && sts_o.tail_gap && pend_v_q) || cmd_i.fin) begin
      out_q.status         <= cmd_i.fin ? status_q : STS_OK;
      out_q.gap_valid      <= pend_v_q;
      out_q.gap_start      <= pend_v_q ? pend_s_q : '0;
      out_q.gap_length     <= pend_v_q ? pend_l_q : '0;
      out_q.last           <= cmd_i.fin;
      out_q.complete       <= complete;
      out_q.received_bytes <= bytes_q;
      out_q.stored_ranges  <= 5'(total_q);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/reception_range_tracker_unit.sv @@
// An add scans the stored ranges and merges the new range into them; a zero-length or overflowing
// add skips the scan and goes straight to its final result. A gap query stops scanning once past
// its window, and its scan waits while a held result is stalled at the output. One item is handled
// at a time; the next item is taken the cycle after the final result is loaded. Reset clears the
// range count, byte total, block_length and handshake state only.
module reception_range_tracker_unit import rrt_pkg::*; #(
  parameter int unsigned MAX_RANGES = DEF_MAX_RANGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  rrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  rrt_datapath #(
    .MAX_RANGES (MAX_RANGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/rrt_checker.sv @@
// Port-level checks of the reception range tracker and their binding.
module rrt_checker import rrt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // One item at a time: input stalls right after an item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while busy");

  // A reported gap is never empty; a result without a gap carries zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.gap_valid ? (out_item_o.gap_length != '0) :
                     (out_item_o.gap_length == '0 && out_item_o.gap_start == '0)))
    else $error("bad gap fields");

  // Only the final result of an item may carry a non-ok status; every other result carries a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.status == STS_OK && out_item_o.gap_valid)
    else $error("non-final result without gap");

endmodule

bind reception_range_tracker_unit rrt_checker u_rrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
